@@ hw/rtl/fcpg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fcpg_pkg
// Types and constants shared by the filled circle pixel generator modules.
// ----------------------------------------------------------------------------
package fcpg_pkg;

	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 200;
	localparam int RADIUS_MAX    = 1023;

	localparam logic signed [12:0] SCR_W_M1 = 13'(SCREEN_WIDTH - 1);
	localparam logic signed [12:0] SCR_H    = 13'(SCREEN_HEIGHT);
	localparam logic [9:0]         RAD_MAX  = 10'(RADIUS_MAX);

	// request commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_NEXT  = 1'b1;

	// squarer operand select
	localparam logic [1:0] SQ_RAD = 2'd0;
	localparam logic [1:0] SQ_ROW = 2'd1;
	localparam logic [1:0] SQ_COL = 2'd2;

	typedef struct packed {
		logic              command;
		logic signed [11:0] center_x;
		logic signed [11:0] center_y;
		logic [9:0]        radius;
		logic [7:0]        color;
	} req_t;

	typedef struct packed {
		logic       pixel_valid;
		logic [8:0]  pixel_x;
		logic [7:0]  pixel_y;
		logic [15:0] pixel_address;
		logic [7:0]  pixel_color;
		logic       scan_done;
	} rsp_t;

	typedef struct packed {
		logic [1:0] sel;
		logic [9:0] rad;
		logic [9:0] row;
		logic [9:0] col;
	} sq_op_t;

endpackage
`default_nettype wire

@@ hw/rtl/filled_circle_pixel_generator_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// filled_circle_pixel_generator_unit
// Walks a circle's bounding box and returns one on-screen pixel per request.
// ----------------------------------------------------------------------------
// Start request: accept, radius squared, then emit to the result register.
// Next request: an accept step, a setup step per box row reached, a step per
// column tested or row end, then an emit step; the single squarer tests one point a cycle.
// One request is in work at a time; req_stall is high until its result is
// handed to the output register. arst_n clears the sequencer and circle state.
module filled_circle_pixel_generator_unit import fcpg_pkg::*; (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic req_valid,
	output logic       req_stall,
	input  req_t       req,
	output logic       rsp_valid,
	input  wire  logic rsp_stall,
	output rsp_t       rsp
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RSQ  = 3'd1;
	localparam logic [2:0] S_ROW  = 3'd2;
	localparam logic [2:0] S_COL  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]         state_q;
	logic signed [11:0] cx_q, cy_q;
	logic [9:0]         r_q;
	logic [19:0]        rsq_q;
	logic [7:0]         color_q;
	logic signed [12:0] dx_q;
	logic signed [11:0] dy_q;
	logic               active_q;
	logic [19:0]        dysq_q;
	logic signed [12:0] hi_q;
	logic [12:0]        py_q;
	rsp_t               res_q;
	rsp_t               out_q;
	logic               out_valid_q;

	logic               req_acc;
	logic               out_free;
	logic signed [12:0] cx13, r13, neg_cx, lo, hi_lim, hi, py, px;
	logic signed [11:0] r12;
	logic signed [11:0] dy_abs;
	logic signed [12:0] dx_abs;
	logic               dy_past_end, py_on, col_past_end, hit;
	logic [20:0]        dist_sum;
	logic [12:0]        px_u;
	logic [31:0]        addr_full;
	sq_op_t             sq_op;
	logic [19:0]        sq;
	logic [9:0]         r_sat;
	rsp_t               pix_res, done_res;

	assign req_acc  = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !rsp_stall;

	assign cx13   = {cx_q[11], cx_q};
	assign r13    = {3'b000, r_q};
	assign r12    = {2'b00, r_q};
	assign neg_cx = -cx13;
	assign lo     = (dx_q > neg_cx) ? dx_q : neg_cx;
	assign hi_lim = SCR_W_M1 - cx13;
	assign hi     = (r13 < hi_lim) ? r13 : hi_lim;
	assign py     = {cy_q[11], cy_q} + {dy_q[11], dy_q};
	assign dy_past_end = dy_q > r12;
	assign py_on  = (py >= 13'sd0) && (py < SCR_H);
	assign dy_abs = dy_q[11] ? -dy_q : dy_q;
	assign dx_abs = dx_q[12] ? -dx_q : dx_q;
	assign col_past_end = dx_q > hi_q;
	assign r_sat  = (req.radius > RAD_MAX) ? RAD_MAX : req.radius;

	always_comb begin
		sq_op.rad = r_q;
		sq_op.row = dy_abs[9:0];
		sq_op.col = dx_abs[9:0];
		unique case (state_q)
			S_RSQ:   sq_op.sel = SQ_RAD;
			S_ROW:   sq_op.sel = SQ_ROW;
			default: sq_op.sel = SQ_COL;
		endcase
	end

	fcpg_sqr u_sqr (
		.op (sq_op),
		.sq (sq)
	);

	assign dist_sum  = {1'b0, sq} + {1'b0, dysq_q};
	assign hit       = dist_sum <= {1'b0, rsq_q};
	assign px        = cx13 + dx_q;
	assign px_u      = px;
	assign addr_full = {19'b0, py_q} * 32'(SCREEN_WIDTH) + {19'b0, px_u};

	always_comb begin
		pix_res               = '0;
		pix_res.pixel_valid   = 1'b1;
		pix_res.pixel_x       = px_u[8:0];
		pix_res.pixel_y       = py_q[7:0];
		pix_res.pixel_address = addr_full[15:0];
		pix_res.pixel_color   = color_q;
		done_res              = '0;
		done_res.scan_done    = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cx_q     <= '0;
			cy_q     <= '0;
			r_q      <= '0;
			rsq_q    <= '0;
			color_q  <= '0;
			dx_q     <= '0;
			dy_q     <= '0;
			active_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						if (req.command == CMD_START) begin
							cx_q     <= req.center_x;
							cy_q     <= req.center_y;
							r_q      <= r_sat;
							color_q  <= req.color;
							dx_q     <= -{3'b000, r_sat};
							dy_q     <= -{2'b00, r_sat};
							active_q <= 1'b1;
							state_q  <= S_RSQ;
						end else if (!active_q) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_ROW;
						end
					end
				end
				S_RSQ: begin
					rsq_q   <= sq;
					state_q <= S_EMIT;
				end
				S_ROW: begin
					if (dy_past_end) begin
						active_q <= 1'b0;
						state_q  <= S_EMIT;
					end else if (!py_on) begin
						dy_q <= dy_q + 12'sd1;
						dx_q <= -r13;
					end else begin
						dx_q    <= lo;
						state_q <= S_COL;
					end
				end
				S_COL: begin
					if (col_past_end) begin
						dy_q    <= dy_q + 12'sd1;
						dx_q    <= -r13;
						state_q <= S_ROW;
					end else if (hit) begin
						// set up the resume point after this pixel
						if (dx_q < r13) begin
							dx_q <= dx_q + 13'sd1;
						end else if (dy_q < r12) begin
							dx_q <= -r13;
							dy_q <= dy_q + 12'sd1;
						end else begin
							active_q <= 1'b0;
						end
						state_q <= S_EMIT;
					end else begin
						dx_q <= dx_q + 13'sd1;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// row setup and pending result payload
	always_ff @(posedge clk) begin
		if (state_q == S_ROW) begin
			dysq_q <= sq;
			hi_q   <= hi;
			py_q   <= py;
		end
		priority if (state_q == S_IDLE && req_acc) begin
			res_q <= (req.command == CMD_START) ? '0 : done_res;
		end else if (state_q == S_ROW && dy_past_end) begin
			res_q <= done_res;
		end else if (state_q == S_COL && !col_past_end && hit) begin
			res_q <= pix_res;
		end else begin
			res_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_start_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.command == CMD_START) |=> (state_q == S_RSQ))
		else $error("start request did not enter radius setup");

	a_rsp_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.pixel_valid && rsp.scan_done))
		else $error("result flags both pixel and done");

	a_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.pixel_valid) |->
		(rsp.pixel_x < 9'(SCREEN_WIDTH)) && (rsp.pixel_y < 8'(SCREEN_HEIGHT)))
		else $error("pixel off screen");

	a_col_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COL) |-> (dx_q >= -r13))
		else $error("column scan left the bounding box");

endmodule
`default_nettype wire

@@ hw/rtl/fcpg_sqr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fcpg_sqr
// Shared squarer: picks radius, row offset or column offset magnitude and
// returns its square.
// ----------------------------------------------------------------------------
module fcpg_sqr import fcpg_pkg::*; (
	input  sq_op_t      op,
	output logic [19:0] sq
);

	logic [9:0] operand;

	always_comb begin
		unique case (op.sel)
			SQ_RAD:  operand = op.rad;
			SQ_ROW:  operand = op.row;
			SQ_COL:  operand = op.col;
			default: operand = op.col;
		endcase
	end

	assign sq = operand * operand;

endmodule
`default_nettype wire

@@ sim/fcpg_pixel_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fcpg_pixel_checker
// Watches both channels of the filled circle pixel generator. It keeps its
// own copy of the circle and scan state, works out the result of every
// accepted request and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module fcpg_pixel_checker import fcpg_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire logic req_stall,
	input  wire req_t req,
	input  wire logic rsp_valid,
	input  wire logic rsp_stall,
	input  wire rsp_t rsp,
	output int        fail_count,
	output int        pending,
	output int        pixel_count,
	output int        done_count
);

	int         circle_cx;
	int         circle_cy;
	int         circle_r;
	int         circle_r2;
	logic [7:0] circle_color;
	int         scan_dx;
	int         scan_dy;
	bit         scan_live;
	rsp_t       pixel_expect_q[$];

	function automatic rsp_t rasterize_request(input req_t item);
		rsp_t res;
		int   dy;
		int   lo;
		int   hi;
		int   py;
		res = '0;
		if (item.command == CMD_START) begin
			circle_cx    = $signed(item.center_x);
			circle_cy    = $signed(item.center_y);
			circle_r     = (item.radius > RAD_MAX) ? RADIUS_MAX : int'(item.radius);
			circle_r2    = circle_r * circle_r;
			circle_color = item.color;
			scan_dx      = -circle_r;
			scan_dy      = -circle_r;
			scan_live    = 1'b1;
			return res;
		end
		if (!scan_live) begin
			res.scan_done = 1'b1;
			return res;
		end
		dy = scan_dy;
		lo = scan_dx;
		while (dy <= circle_r) begin
			py = circle_cy + dy;
			if (py >= 0 && py < SCREEN_HEIGHT) begin
				// clip the row to the visible columns
				if (circle_cx + lo < 0)
					lo = -circle_cx;
				hi = circle_r;
				if (circle_cx + hi > SCREEN_WIDTH - 1)
					hi = SCREEN_WIDTH - 1 - circle_cx;
				while (lo <= hi) begin
					if (lo * lo + dy * dy <= circle_r2) begin
						// resume one column right, at the next row, or retire the circle
						if (lo < circle_r) begin
							scan_dx = lo + 1;
							scan_dy = dy;
						end else if (dy < circle_r) begin
							scan_dx = -circle_r;
							scan_dy = dy + 1;
						end else begin
							scan_live = 1'b0;
						end
						res.pixel_valid   = 1'b1;
						res.pixel_x       = 9'(circle_cx + lo);
						res.pixel_y       = 8'(py);
						res.pixel_address = 16'(py * SCREEN_WIDTH + circle_cx + lo);
						res.pixel_color   = circle_color;
						return res;
					end
					lo++;
				end
			end
			dy++;
			lo = -circle_r;
		end
		scan_live     = 1'b0;
		res.scan_done = 1'b1;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		bit   bad;
		if (!arst_n) begin
			circle_cx    = 0;
			circle_cy    = 0;
			circle_r     = 0;
			circle_r2    = 0;
			circle_color = '0;
			scan_dx      = 0;
			scan_dy      = 0;
			scan_live    = 1'b0;
			pixel_expect_q.delete();
			fail_count   = 0;
			pending      = 0;
			pixel_count  = 0;
			done_count   = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pixel_expect_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result with nothing outstanding: valid=%0d x=%0d y=%0d addr=%0d color=%0d done=%0d",
							$realtime, rsp.pixel_valid, rsp.pixel_x, rsp.pixel_y,
							rsp.pixel_address, rsp.pixel_color, rsp.scan_done);
				end else begin
					want = pixel_expect_q.pop_front();
					if (want.pixel_valid)
						pixel_count++;
					if (want.scan_done)
						done_count++;
					bad = (rsp.pixel_valid   !== want.pixel_valid)   ||
					      (rsp.pixel_x       !== want.pixel_x)       ||
					      (rsp.pixel_y       !== want.pixel_y)       ||
					      (rsp.pixel_address !== want.pixel_address) ||
					      (rsp.pixel_color   !== want.pixel_color)   ||
					      (rsp.scan_done     !== want.scan_done);
					if (bad) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: mismatch exp valid=%0d x=%0d y=%0d addr=%0d color=%0d done=%0d",
								$realtime, want.pixel_valid, want.pixel_x, want.pixel_y,
								want.pixel_address, want.pixel_color, want.scan_done);
							$display("%0t:          got valid=%0d x=%0d y=%0d addr=%0d color=%0d done=%0d",
								$realtime, rsp.pixel_valid, rsp.pixel_x, rsp.pixel_y,
								rsp.pixel_address, rsp.pixel_color, rsp.scan_done);
						end
					end
				end
			end
			if (req_valid && !req_stall)
				pixel_expect_q.push_back(rasterize_request(req));
			pending = pixel_expect_q.size();
		end
	end

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Drives the filled circle pixel generator with directed corner circles and
// then random circle walks, with random gaps on the request side and random
// stalls on the result side. The checker beside the block does the compare.
// ----------------------------------------------------------------------------
module tb import fcpg_pkg::*; ();

	localparam int ITEM_TARGET  = 1000;
	localparam int CYCLE_LIMIT  = 250_000_000;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	int fail_count;
	int pending;
	int pixel_count;
	int done_count;

	int reqs_sent;
	int circles_started;
	int cycle_count;
	bit quiet;
	bit rsp_holding;
	int rsp_seg_left;

	filled_circle_pixel_generator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	fcpg_pixel_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.pending     (pending),
		.pixel_count (pixel_count),
		.done_count  (done_count)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// mostly short idle stretches, a few long ones, none while quiet
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (quiet || pick < 45)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// alternate stall and run segments on the result side
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_seg_left == 0) begin
				if (rsp_holding || quiet) begin
					rsp_holding  = 1'b0;
					rsp_seg_left = $urandom_range(1, 12);
				end else begin
					rsp_holding  = 1'b1;
					rsp_seg_left = idle_len() + 1;
				end
			end
			rsp_seg_left--;
			rsp_stall <= rsp_holding;
		end
	end

	function automatic req_t start_req(input int cx, input int cy, input int r, input int col);
		req_t item;
		item.command  = CMD_START;
		item.center_x = 12'(cx);
		item.center_y = 12'(cy);
		item.radius   = 10'(r);
		item.color    = 8'(col);
		return item;
	endfunction

	// unused fields of a next request carry random content
	function automatic req_t next_req();
		logic [63:0] bits;
		req_t        item;
		bits         = {$urandom, $urandom};
		item         = req_t'(bits[$bits(req_t)-1:0]);
		item.command = CMD_NEXT;
		return item;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_req(input req_t item);
		int gap;
		gap = idle_len();
		if ($urandom_range(0, 79) == 0)
			quiet = !quiet;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		reqs_sent++;
		if (item.command == CMD_START)
			circles_started++;
	endtask

	task automatic walk_circle(input int cx, input int cy, input int r, input int col,
	                           input int steps);
		send_req(start_req(cx, cy, r, col));
		repeat (steps) send_req(next_req());
	endtask

	initial begin
		int          pick;
		int          r;
		logic [63:0] bits;
		arst_n          = 1'b0;
		req_valid       = 1'b0;
		req             = '0;
		rsp_stall       = 1'b0;
		quiet           = 1'b0;
		rsp_holding     = 1'b0;
		rsp_seg_left    = 0;
		reqs_sent       = 0;
		circles_started = 0;
		cycle_count     = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// next with no circle yet
		send_req(next_req());
		// single pixel circles at the screen corners, then done
		walk_circle(0, 0, 0, 255, 2);
		walk_circle(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 0, 2);
		// largest circles fully off screen: the whole box walks to done
		walk_circle(-2048, -2048, RADIUS_MAX, 8'h55, 2);
		walk_circle(2047, 2047, RADIUS_MAX, 8'h0f, 1);
		// largest circle over the whole screen, interrupted by a new start
		walk_circle(SCREEN_WIDTH / 2, SCREEN_HEIGHT / 2, RADIUS_MAX, 8'haa, 3);
		// box overlaps the corner but no point of the circle is visible
		walk_circle(-1, -1, 1, 8'hf0, 1);
		// clipped at the top right edge
		walk_circle(SCREEN_WIDTH - 1, -2, 3, 8'h3c, 4);

		while (reqs_sent < ITEM_TARGET + 25) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				r = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3) : $urandom_range(4, 12);
				// small circles run to the end; larger ones are cut short
				walk_circle(int'($urandom_range(0, 360)) - 20, int'($urandom_range(0, 240)) - 20,
					r, $urandom_range(0, 255),
					(r <= 3) ? (2 * r + 1) * (2 * r + 1) + $urandom_range(1, 2)
					         : $urandom_range(1, 30));
			end else if (pick < 88) begin
				walk_circle(int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
					$urandom_range(0, 1023), $urandom_range(0, 255), $urandom_range(1, 6));
			end else begin
				bits = {$urandom, $urandom};
				send_req(req_t'(bits[$bits(req_t)-1:0]));
			end
		end
		req_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d requests over %0d circles, incl. full-size, clipped and off-screen ones",
			reqs_sent, circles_started);
		$display("%0d pixel writes and %0d done results checked, %0d failures",
			pixel_count, done_count, fail_count);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire

@@ filelist.f @@
hw/rtl/fcpg_pkg.sv
hw/rtl/fcpg_sqr.sv
hw/rtl/filled_circle_pixel_generator_unit.sv
sim/fcpg_pixel_checker.sv
sim/tb.sv
